>>> hw/rtl/bitmap_page_frame_allocator_assert.svh
// assertion macros for the page frame allocator
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
// implication checked every clock, quiet in reset
`define BPFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BPFA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/bpfa_pkg.sv
// package for the page frame allocator: constants and codes
package bpfa_pkg;
  localparam int unsigned FRAMES_DEF    = 32768;
  localparam int unsigned PAGE_BITS_DEF = 12;
  localparam logic [1:0] OP_RESERVE  = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_ALLOC    = 2'd2;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_DBL_FREE = 2'd2;
  localparam logic [20:0] LIMIT_RST  = 21'd32768;
  localparam logic [1:0] REG_BASE    = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
endpackage

>>> hw/rtl/bitmap_page_frame_allocator.sv
// top level of the bitmap page frame allocator
//
// channel | direction | handshake            | payload
// in_     | in        | start & !busy        | in_op, in_address, in_length, in_page_aligned
// out_    | out       | done strobe, 1 cycle | out_status, out_alloc_address
// cfg_    | in        | apb, pready tied 1   | base_frame, frame_limit
//
// after reset a clearing pass writes every bitmap entry, busy high
// reserve and free step through each frame in range, a read state then a write or check state
// allocate reads and checks each frame searched, then marks the found block as a reserve does
// the cost is set by the one bitmap ram port, one frame read or written a step
// the result strobe lasts one cycle; the receiver cannot stall
module bitmap_page_frame_allocator #(
  parameter int unsigned FRAMES = bpfa_pkg::FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_address,
  input  logic [31:0] in_length,
  input  logic        in_page_aligned,
  output logic        done,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // frame cursors are 22 bits wide; the page size comes from PAGE_BITS_DEF in the package
  localparam int unsigned PAGE_BITS = bpfa_pkg::PAGE_BITS_DEF;
  localparam int unsigned AW = $clog2(FRAMES);
  localparam logic [33:0] PMASK = (34'd1 << PAGE_BITS) - 34'd1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_MRD, S_MWR, S_FRD, S_FCHK,
    S_SRD, S_SCHK, S_PACK, S_DONE
  } state_t;

  state_t       state_r;
  logic [19:0]  base_r;
  logic [20:0]  limit_r;
  logic [19:0]  lastf_r;
  logic [PAGE_BITS-1:0] lasto_r;
  logic [1:0]   op_r;
  logic [31:0]  addr_r, len_r;
  logic         aln_r;
  logic [21:0]  p_r, hi_r;        // frame cursor and end, no wrap
  logic [21:0]  blk_r;
  logic [21:0]  found_r, need_r;
  logic [33:0]  pa_r;
  logic [1:0]   st_r;
  logic [31:0]  res_r;
  logic         done_r;
  logic [AW-1:0] clr_r;

  // shared unit: window check and ram index of the cursor frame
  logic        in_win;
  logic [21:0] rel;
  logic [22:0] top;
  logic [AW-1:0] ram_addr;
  logic        ram_we, ram_wd, ram_rd;

  assign top    = {3'd0, base_r} + 23'(FRAMES);
  assign rel    = p_r - {2'd0, base_r};
  assign in_win = (p_r >= {2'd0, base_r}) && ({1'b0, p_r} < top);

  always_comb begin
    ram_we   = 1'b0;
    ram_wd   = 1'b0;
    ram_addr = rel[AW-1:0];
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
      ram_addr = clr_r;
    end else if (state_r == S_MWR) begin
      ram_we = in_win;
      ram_wd = 1'b1;
    end else if (state_r == S_FCHK) begin
      ram_we = ram_rd;
    end
  end

  bpfa_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_map (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      bpfa_pkg::REG_BASE[0]: prdata = {12'd0, base_r};
      default:               prdata = {11'd0, limit_r};
    endcase
  end

  // range end clamps for mark and free
  logic [33:0] m_lo, m_hi, f_lo, f_hi, mend;
  logic [21:0] cl_lo, cl_hi;
  logic [21:0] c_lo_in, c_hi_in;
  always_comb begin
    m_lo = {2'd0, addr_r} >> PAGE_BITS;
    m_hi = ({2'd0, addr_r} + {2'd0, len_r} + PMASK) >> PAGE_BITS;
    f_lo = ({2'd0, addr_r} + PMASK) >> PAGE_BITS;
    f_hi = ({2'd0, addr_r} + {2'd0, len_r}) >> PAGE_BITS;
    c_lo_in = (op_r == bpfa_pkg::OP_FREE) ? f_lo[21:0] : m_lo[21:0];
    c_hi_in = (op_r == bpfa_pkg::OP_FREE) ? f_hi[21:0] : m_hi[21:0];
    cl_lo = (c_lo_in < {2'd0, base_r}) ? {2'd0, base_r} : c_lo_in;
    cl_hi = ({1'b0, c_hi_in} > top) ? top[21:0] : c_hi_in;
    mend  = pa_r + {2'd0, len_r};
  end

  // clamped frame range of the allocated block
  logic [21:0] pa_lo_c, pa_hi_c;
  logic [33:0] pa_lo_raw, pa_hi_raw;
  assign pa_lo_raw = pa_r >> PAGE_BITS;
  assign pa_hi_raw = (mend + PMASK) >> PAGE_BITS;
  assign pa_lo_c = (pa_lo_raw[21:0] < {2'd0, base_r}) ? {2'd0, base_r} : pa_lo_raw[21:0];
  assign pa_hi_c = ({1'b0, pa_hi_raw[21:0]} > top) ? top[21:0] : pa_hi_raw[21:0];

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      base_r  <= '0;
      limit_r <= bpfa_pkg::LIMIT_RST;
      lastf_r <= '0;
      lasto_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2:2] == bpfa_pkg::REG_BASE[0:0]) base_r <= pwdata[19:0];
        else if (paddr[2:2] == bpfa_pkg::REG_LIMIT[0:0]) limit_r <= pwdata[20:0];
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(FRAMES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          op_r <= in_op; addr_r <= in_address; len_r <= in_length;
          aln_r <= in_page_aligned;
          st_r <= bpfa_pkg::ST_OK; res_r <= '0;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          case (op_r)
            bpfa_pkg::OP_RESERVE: begin
              if (res_r != '0) begin
                // allocation in flight: mark the block and record its tail
                p_r     <= pa_lo_c;
                hi_r    <= pa_hi_c;
                res_r   <= pa_r[31:0];
                lastf_r <= 20'((mend - 34'd1) >> PAGE_BITS);
                lasto_r <= mend[PAGE_BITS-1:0];
              end else begin
                p_r <= cl_lo; hi_r <= cl_hi;
              end
              state_r <= S_MRD;
            end
            bpfa_pkg::OP_FREE: begin
              p_r <= cl_lo; hi_r <= cl_hi; state_r <= S_FRD;
            end
            bpfa_pkg::OP_ALLOC: begin
              need_r  <= 22'(({2'd0, len_r} + PMASK) >> PAGE_BITS);
              blk_r   <= m_lo[21:0];
              p_r     <= m_lo[21:0];
              found_r <= '0;
              if (len_r == '0) begin
                st_r <= bpfa_pkg::ST_NO_SPACE; state_r <= S_DONE;
              end else state_r <= S_SRD;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_MRD: state_r <= (p_r < hi_r) ? S_MWR : S_DONE;
        S_MWR: begin p_r <= p_r + 22'd1; state_r <= S_MRD; end
        S_FRD: state_r <= (p_r < hi_r) ? S_FCHK : S_DONE;
        S_FCHK: begin
          if (!ram_rd) begin
            st_r <= bpfa_pkg::ST_DBL_FREE; state_r <= S_DONE;
          end else begin
            p_r <= p_r + 22'd1; state_r <= S_FRD;
          end
        end
        S_SRD: begin
          if (found_r >= need_r) state_r <= S_PACK;
          else if (p_r >= {1'b0, limit_r}) begin
            st_r <= bpfa_pkg::ST_NO_SPACE; state_r <= S_DONE;
          end else state_r <= S_SCHK;
        end
        S_SCHK: begin
          if (!in_win || ram_rd) begin
            blk_r <= p_r + 22'd1; found_r <= '0;
          end else found_r <= found_r + 22'd1;
          p_r <= p_r + 22'd1;
          state_r <= S_SRD;
        end
        S_PACK: begin
          if (blk_r == {2'd0, lastf_r} + 22'd1 && lasto_r != '0 && !aln_r)
            pa_r <= ({12'd0, blk_r} << PAGE_BITS) - (PMASK + 34'd1) +
                    {{(34-PAGE_BITS){1'b0}}, lasto_r};
          else pa_r <= {12'd0, blk_r} << PAGE_BITS;
          op_r <= bpfa_pkg::OP_RESERVE;
          state_r <= S_SETUP;
          res_r <= 32'hFFFF_FFFF; // marker: allocation in flight
        end
        default: begin // S_DONE
          done_r <= 1'b1;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;
  assign out_status = st_r;
  assign out_alloc_address = (st_r == bpfa_pkg::ST_OK) ? res_r : 32'd0;
endmodule

>>> hw/rtl/bpfa_ram.sv
// generic single-port ram with registered read
module bpfa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/bpfa_checker.sv
// port-level checker for the page frame allocator, with its bind
`include "bitmap_page_frame_allocator_assert.svh"
module bpfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  out_status,
  input logic [31:0] out_alloc_address
);
  `BPFA_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `BPFA_ASSERT_IMP(a_done_busy, done, !busy)
  `BPFA_ASSERT_IMP(a_fail_zero, done && out_status != bpfa_pkg::ST_OK, out_alloc_address == 32'd0)
  `BPFA_ASSERT_NXT(a_done_once, done, !done)
endmodule

bind bitmap_page_frame_allocator bpfa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
  .out_status(out_status), .out_alloc_address(out_alloc_address)
);
